// ===== rtl/core/dou_pkg.sv =====
// ----------------------------------------------------------------------------
// dou_pkg
// Types and constants shared by the converter output update engine.
// ----------------------------------------------------------------------------
package dou_pkg;

  localparam int CODE_W = 12;
  localparam int CNT_W  = 32;
  localparam int ADDR_W = 7;

  typedef logic [CODE_W-1:0] code_t;

  // mode codes
  localparam logic [1:0] MODE_ALL  = 2'd0;
  localparam logic [1:0] MODE_PER  = 2'd1;
  localparam logic [1:0] MODE_RAW  = 2'd2;
  localparam logic [1:0] MODE_RSVD = 2'd3;

  localparam logic [ADDR_W-1:0] DEV_ADDR_RST = 7'd96;

  localparam code_t       CODE_FULL = 12'd4095;
  localparam logic [7:0]  CMD_BASE  = 8'h40;

  // millivolt clamp limits and breakpoints
  localparam logic signed [15:0] MV_LOW = -16'sd3000;
  localparam logic signed [15:0] MV_MID = 16'sd0;
  localparam logic signed [15:0] MV_BP3 = 16'sd3000;
  localparam logic signed [15:0] MV_HIGH = 16'sd6000;

  localparam code_t CODE_BP1 = 12'd1229;
  localparam code_t CODE_BP2 = 12'd2168;
  localparam code_t CODE_BP3 = 12'd3107;
  localparam code_t CODE_BP4 = 12'd4042;

  localparam logic [9:0] SLOPE_A = 10'(CODE_BP2 - CODE_BP1);
  localparam logic [9:0] SLOPE_B = 10'(CODE_BP3 - CODE_BP2);
  localparam logic [9:0] SLOPE_C = 10'(CODE_BP4 - CODE_BP3);

  // every segment spans 3000 mV; divide by multiplying with 2^32/3000
  localparam logic [21:0] SEG_SPAN    = 22'd3000;
  localparam logic [21:0] HALF_SPAN   = 22'd1500;
  localparam logic [20:0] SPAN_RECIP  = 21'd1431655;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] value_0;
    logic signed [15:0] value_1;
    logic signed [15:0] value_2;
    logic signed [15:0] value_3;
  } in_item_t;

  typedef struct packed {
    logic              skipped;
    logic [1:0]        channel;
    logic [ADDR_W-1:0] target_address;
    logic [7:0]        command_byte;
    logic [3:0]        data_high;
    logic [7:0]        data_low;
    logic              last;
    logic [CNT_W-1:0]  update_calls;
    logic [CNT_W-1:0]  skipped_calls;
    logic [CNT_W-1:0]  frames_sent;
    logic [CNT_W-1:0]  frames_skipped;
  } out_item_t;

endpackage

// ===== rtl/core/dou_lane.sv =====
// ----------------------------------------------------------------------------
// dou_lane
// Four-stage per-channel code conversion: clamp and segment select,
// slope multiply, reciprocal divide, remainder correction.
// ----------------------------------------------------------------------------
module dou_lane
  import dou_pkg::*;
(
  input  logic               clk,
  input  logic [3:0]         ld,
  input  logic               raw,
  input  logic signed [15:0] value,
  output code_t              code
);

  logic               s1_raw_r;
  code_t              s1_rcode_r;
  logic [11:0]        s1_d_r;
  logic [9:0]         s1_slope_r;
  code_t              s1_base_r;

  logic               s2_raw_r;
  code_t              s2_rcode_r;
  logic [21:0]        s2_num_r;
  code_t              s2_base_r;

  logic               s3_raw_r;
  code_t              s3_rcode_r;
  logic [21:0]        s3_num_r;
  logic [9:0]         s3_q_r;
  code_t              s3_base_r;

  code_t              code_r;

  code_t              rcode;
  logic signed [15:0] mv;
  logic signed [15:0] x0;
  logic signed [16:0] diff;
  logic [9:0]         slope;
  code_t              base;
  logic [42:0]        prod;
  logic [21:0]        rem;
  logic [9:0]         q;

  always_comb begin
    if (value < 16'sd0) begin
      rcode = '0;
    end else if (value > 16'sd4095) begin
      rcode = CODE_FULL;
    end else begin
      rcode = value[11:0];
    end

    if (value < MV_LOW) begin
      mv = MV_LOW;
    end else if (value > MV_HIGH) begin
      mv = MV_HIGH;
    end else begin
      mv = value;
    end

    if (mv < MV_MID) begin
      x0 = MV_LOW;
      slope = SLOPE_A;
      base = CODE_BP1;
    end else if (mv < MV_BP3) begin
      x0 = MV_MID;
      slope = SLOPE_B;
      base = CODE_BP2;
    end else begin
      x0 = MV_BP3;
      slope = SLOPE_C;
      base = CODE_BP3;
    end
    diff = 17'(mv) - 17'(x0);

    prod = 43'(s2_num_r) * 43'(SPAN_RECIP);

    rem = s3_num_r - 22'(22'(s3_q_r) * SEG_SPAN);
    q = (rem >= SEG_SPAN) ? s3_q_r + 10'd1 : s3_q_r;
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s1_raw_r   <= raw;
      s1_rcode_r <= rcode;
      s1_d_r     <= diff[11:0];
      s1_slope_r <= slope;
      s1_base_r  <= base;
    end
    if (ld[1]) begin
      s2_raw_r   <= s1_raw_r;
      s2_rcode_r <= s1_rcode_r;
      s2_num_r   <= 22'(22'(s1_d_r) * 22'(s1_slope_r)) + HALF_SPAN;
      s2_base_r  <= s1_base_r;
    end
    if (ld[2]) begin
      s3_raw_r   <= s2_raw_r;
      s3_rcode_r <= s2_rcode_r;
      s3_num_r   <= s2_num_r;
      s3_q_r     <= prod[41:32];
      s3_base_r  <= s2_base_r;
    end
    if (ld[3]) begin
      code_r <= s3_raw_r ? s3_rcode_r : s3_base_r + code_t'(q);
    end
  end

  assign code = code_r;

endmodule

// ===== rtl/core/dou_merge.sv =====
// ----------------------------------------------------------------------------
// dou_merge
// Compares lane codes with the channel cache, issues skip or frame results
// one per unstalled cycle, keeps the diagnostic counters and output register.
// ----------------------------------------------------------------------------
module dou_merge
  import dou_pkg::*;
#(
  parameter int CHANNELS = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [ADDR_W-1:0]          dev_addr,
  input  logic                       lane_valid,
  input  logic [CHANNELS-1:0][11:0]  codes,
  output logic                       take,
  output logic                       out_valid,
  input  logic                       out_stall,
  output out_item_t                  out_item
);

  localparam int NW = $clog2(CHANNELS + 1);

  code_t [CHANNELS-1:0]       cache_r;
  logic                       cache_valid_r;
  code_t [CHANNELS-1:0]       codes_r;
  logic [CHANNELS-1:0]        rem_r;
  logic [CNT_W-1:0]           upd_r, upd_nxt;
  logic [CNT_W-1:0]           skp_r, skp_nxt;
  logic [CNT_W-1:0]           frm_r, frm_nxt;
  logic [CNT_W-1:0]           fsk_r, fsk_nxt;
  logic                       out_valid_r;
  out_item_t                  out_r, out_nxt;

  logic                       out_ld;
  logic                       busy;
  logic                       emit;
  logic                       is_skip;
  logic [CHANNELS-1:0]        chg;
  logic [CHANNELS-1:0]        src_mask;
  logic [CHANNELS-1:0]        pick;
  code_t [CHANNELS-1:0]       src_codes;
  logic [NW-1:0]              nchg;
  code_t                      sel_code;
  logic [1:0]                 sel_ch;
  code_t                      hw;

  always_comb begin
    out_ld = !out_valid_r || !out_stall;
    busy = |rem_r;
    take = lane_valid && !busy && out_ld;
    emit = out_ld && (busy || lane_valid);

    nchg = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      chg[i] = !cache_valid_r || (codes[i] != cache_r[i]);
      nchg = nchg + NW'(chg[i]);
    end

    src_mask = busy ? rem_r : chg;
    src_codes = busy ? codes_r : codes;
    pick = src_mask & (~src_mask + 1'b1);
    is_skip = !busy && (chg == '0);

    sel_code = '0;
    sel_ch = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (pick[i]) begin
        sel_code = src_codes[i];
        sel_ch = 2'(i);
      end
    end
    hw = CODE_FULL - sel_code;

    upd_nxt = upd_r;
    skp_nxt = skp_r;
    frm_nxt = frm_r;
    fsk_nxt = fsk_r;
    if (take) begin
      if (is_skip) begin
        skp_nxt = skp_r + 32'd1;
        fsk_nxt = fsk_r + 32'(CHANNELS);
      end else begin
        upd_nxt = upd_r + 32'd1;
        frm_nxt = frm_r + 32'(nchg);
        fsk_nxt = fsk_r + (32'(CHANNELS) - 32'(nchg));
      end
    end

    out_nxt.target_address = dev_addr;
    out_nxt.update_calls   = upd_nxt;
    out_nxt.skipped_calls  = skp_nxt;
    out_nxt.frames_sent    = frm_nxt;
    out_nxt.frames_skipped = fsk_nxt;
    if (is_skip) begin
      out_nxt.skipped      = 1'b1;
      out_nxt.channel      = '0;
      out_nxt.command_byte = '0;
      out_nxt.data_high    = '0;
      out_nxt.data_low     = '0;
      out_nxt.last         = 1'b1;
    end else begin
      out_nxt.skipped      = 1'b0;
      out_nxt.channel      = sel_ch;
      out_nxt.command_byte = CMD_BASE | {5'd0, sel_ch, 1'b0};
      out_nxt.data_high    = hw[11:8];
      out_nxt.data_low     = hw[7:0];
      out_nxt.last         = ((src_mask & ~pick) == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cache_valid_r <= 1'b0;
      rem_r         <= '0;
      upd_r         <= '0;
      skp_r         <= '0;
      frm_r         <= '0;
      fsk_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      upd_r <= upd_nxt;
      skp_r <= skp_nxt;
      frm_r <= frm_nxt;
      fsk_r <= fsk_nxt;
      if (take) begin
        if (!is_skip) begin
          cache_valid_r <= 1'b1;
          rem_r         <= chg & ~pick;
        end
      end else if (busy && out_ld) begin
        rem_r <= rem_r & ~pick;
      end
      if (out_ld) begin
        out_valid_r <= busy || lane_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && !is_skip) begin
      cache_r <= codes;
      codes_r <= codes;
    end
    if (emit) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== rtl/core/dac_output_update_engine_unit.sv =====
// ----------------------------------------------------------------------------
// dac_output_update_engine_unit
// Converts per-item channel levels to converter codes and issues bus frames
// for the channels whose code changed.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_item carry one request: a mode and four values.
//   out_valid/out_stall/out_item carry results: one skip result when no
//   channel changed, otherwise one frame per changed channel, lowest channel
//   first, with last set on the final one. Counters show the values after
//   the whole item. cfg_we/cfg_wdata set the device bus address.
// Timing:
//   Each lane is a four-stage conversion pipeline; an item's results pass
//   through the four lane stages and then the merge output register. Items
//   enter back to back unless held. The merge stage issues one result per cycle
//   unless stalled, and takes a new item only after the previous one's last frame.
// Reset:
//   Clears the cache (every channel is sent by the next item), the counters
//   and all valid bits; the device address returns to 96.
// Stall:
//   A stalled result holds in the output register; the merge stage and the
//   lane pipeline fill up behind it and in_stall rises once they are full.
// ----------------------------------------------------------------------------
module dac_output_update_engine_unit
  import dou_pkg::*;
#(
  parameter int CHANNELS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_item,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_wdata
);

  logic [ADDR_W-1:0]          dev_addr_r;
  logic [3:0]                 v_r;
  logic [3:0]                 ld;
  logic                       take;
  logic                       raw;
  logic signed [15:0]         vals [4];
  logic [CHANNELS-1:0][11:0]  codes;

  always_comb begin
    ld[3] = !v_r[3] || take;
    for (int i = 2; i >= 0; i--) begin
      ld[i] = !v_r[i] || ld[i+1];
    end
    raw = (in_item.mode == MODE_RAW) || (in_item.mode == MODE_RSVD);
    vals[0] = in_item.value_0;
    vals[1] = in_item.value_1;
    vals[2] = in_item.value_2;
    vals[3] = in_item.value_3;
  end

  assign in_stall = !ld[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r        <= '0;
      dev_addr_r <= DEV_ADDR_RST;
    end else begin
      if (cfg_we) begin
        dev_addr_r <= cfg_wdata;
      end
      if (ld[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < 4; i++) begin
        if (ld[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    dou_lane u_lane (
      .clk   (clk),
      .ld    (ld),
      .raw   (raw),
      .value ((in_item.mode == MODE_ALL) ? in_item.value_0 : vals[g]),
      .code  (codes[g])
    );
  end

  dou_merge #(
    .CHANNELS (CHANNELS)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .dev_addr   (dev_addr_r),
    .lane_valid (v_r[3]),
    .codes      (codes),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v_r[3] && !take))
    else $error("input stalled while the lane pipeline can advance");

  a_skip_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.skipped) |-> (out_item.last && out_item.channel == 2'd0
      && out_item.data_high == 4'd0 && out_item.data_low == 8'd0))
    else $error("skip result carries frame data");

  a_take_free: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> (!out_valid || !out_stall))
    else $error("merge took an item while the output register is held");

endmodule
